/* rtl/lpm_pkg.sv */
// Package for the LIKE matcher: sizes, opcodes and item types.
package lpm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam logic [7:0] WILDCARD = 8'h25;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_EVAL    = 2'd3
  } lpm_op_t;

  typedef struct packed {
    lpm_op_t    operation;
    logic [7:0] data_byte;
    logic       null_operand;
  } lpm_in_t;

  typedef struct packed {
    logic matched;
    logic null_result;
    logic pattern_overflow;
  } lpm_out_t;

  typedef struct packed {
    logic       clear;
    logic       restart;
    logic       advance;
    logic [7:0] data;
  } lpm_ctl_t;

  typedef struct packed {
    logic step;
    logic skip;
  } lpm_link_t;

endpackage

/* rtl/lpm_cell.sv */
// One automaton position: stored pattern byte, in-use flag and active bit.
module lpm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lpm_pkg::lpm_ctl_t ctl,
  input  logic              wr,
  input  logic              head,
  input  logic              seed,
  input  lpm_pkg::lpm_link_t link_in,
  output lpm_pkg::lpm_link_t link_out,
  output logic              lead_wild,
  output logic              act
);
  import lpm_pkg::*;

  logic [7:0] store_r;
  logic       used_r, used_nxt;
  logic       act_r, act_nxt;
  logic       wild, live, hold, pre;
  logic [7:0] store_view;

  assign wild = (store_r == WILDCARD);
  assign live = used_r & act_r;
  assign hold = live & wild;
  assign pre  = hold | link_in.step;

  assign link_out.step = live & ~wild & (store_r == ctl.data);
  assign link_out.skip = used_r & wild & pre;

  assign store_view = wr ? ctl.data : store_r;
  assign lead_wild  = used_nxt & (store_view == WILDCARD);
  assign act        = act_r;

  always_comb begin
    used_nxt = used_r;
    if (ctl.clear) begin
      used_nxt = 1'b0;
    end else if (wr) begin
      used_nxt = 1'b1;
    end
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = seed;
    end else if (ctl.advance) begin
      act_nxt = hold | link_in.step | link_in.skip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= head;
    end else begin
      used_r <= used_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store_r <= ctl.data;
    end
  end

endmodule

/* rtl/like_pattern_matcher_top.sv */
// LIKE matcher top: pattern length control, row of position cells, result register.
// An evaluate item's result is registered and appears on out_valid in the cycle after it is accepted.
// Throughput: one item per cycle while in_stall is low; every cell updates its position in parallel.
// in_stall rises only for an evaluate item while a previous result is still stalled.
// Reset: empty pattern, overflow clear, only position zero active, no result pending.
// The pattern bytes themselves are not cleared; unused cells are masked by their in-use flag.
module like_pattern_matcher_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpm_pkg::lpm_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lpm_pkg::lpm_out_t out_data
);
  import lpm_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             last_wild_r, last_wild_nxt;
  logic             ovf_r, ovf_nxt;
  logic             end_act_r, end_act_nxt;
  logic             out_valid_r, out_valid_nxt;
  lpm_out_t         out_data_r, out_data_nxt;

  logic             in_acc, is_clear, is_append, is_subject, is_eval;
  logic             byte_wild, collapse, full, store_byte, hit;
  lpm_ctl_t         ctl;
  lpm_link_t        link [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lead;
  logic [PATTERN_MAX:0]   act_vec;

  assign in_stall   = out_valid_r & out_stall & (in_data.operation == OP_EVAL);
  assign in_acc     = in_valid & ~in_stall;
  assign is_clear   = in_acc & (in_data.operation == OP_CLEAR);
  assign is_append  = in_acc & (in_data.operation == OP_APPEND);
  assign is_subject = in_acc & (in_data.operation == OP_SUBJECT);
  assign is_eval    = in_acc & (in_data.operation == OP_EVAL);

  assign byte_wild  = (in_data.data_byte == WILDCARD);
  assign collapse   = byte_wild & last_wild_r;
  assign full       = (len_r == LEN_W'(PATTERN_MAX));
  assign store_byte = is_append & ~collapse & ~full;

  assign ctl.clear   = is_clear;
  assign ctl.restart = is_clear | is_append | is_eval;
  assign ctl.advance = is_subject;
  assign ctl.data    = in_data.data_byte;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic      wr_i, seed_i;
      lpm_link_t lin_i;
      assign wr_i = store_byte & (len_r == LEN_W'(gi));
      if (gi == 0) begin : g_first
        assign seed_i = 1'b1;
        assign lin_i  = '0;
      end else if (gi == 1) begin : g_second
        assign seed_i = lead[0];
        assign lin_i  = link[gi-1];
      end else begin : g_rest
        assign seed_i = 1'b0;
        assign lin_i  = link[gi-1];
      end
      lpm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr       (wr_i),
        .head     ((gi == 0) ? 1'b1 : 1'b0),
        .seed     (seed_i),
        .link_in  (lin_i),
        .link_out (link[gi]),
        .lead_wild(lead[gi]),
        .act      (act_vec[gi])
      );
    end
  endgenerate

  assign act_vec[PATTERN_MAX] = end_act_r;
  assign hit = act_vec[len_r];

  always_comb begin
    len_nxt       = len_r;
    last_wild_nxt = last_wild_r;
    ovf_nxt       = ovf_r;
    end_act_nxt   = end_act_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (is_clear) begin
      len_nxt       = '0;
      last_wild_nxt = 1'b0;
      ovf_nxt       = 1'b0;
    end else if (is_append & ~collapse) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt       = len_r + LEN_W'(1);
        last_wild_nxt = byte_wild;
      end
    end
    if (ctl.restart) begin
      end_act_nxt = 1'b0;
    end else if (is_subject) begin
      end_act_nxt = link[PATTERN_MAX-1].step | link[PATTERN_MAX-1].skip;
    end
    if (is_eval) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.matched          = hit & ~in_data.null_operand & ~ovf_r;
      out_data_nxt.null_result      = in_data.null_operand;
      out_data_nxt.pattern_overflow = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      last_wild_r <= 1'b0;
      ovf_r       <= 1'b0;
      end_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      last_wild_r <= last_wild_nxt;
      ovf_r       <= ovf_nxt;
      end_act_r   <= end_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length past store size");

  a_last_wild_len: assert property (@(posedge clk) disable iff (!rst_n)
    last_wild_r |-> (len_r != '0))
    else $error("trailing wildcard flag with empty pattern");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    is_clear |=> (len_r == '0) && !ovf_r && !last_wild_r)
    else $error("clear left pattern state behind");

  a_restart_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.restart |=> act_vec[0] && !end_act_r)
    else $error("restart did not reseed the automaton");

  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_eval |=> out_valid_r && (out_data_r.pattern_overflow == $past(ovf_r)))
    else $error("evaluate item produced no result");
`endif

endmodule

/* tb/tb_like_pattern_matcher_top.sv */
// Self-checking testbench for the LIKE pattern matcher top level.
module tb_like_pattern_matcher_top;
  import lpm_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  lpm_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  lpm_out_t out_data;

  like_pattern_matcher_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // matcher state as the block should hold it
  logic [7:0]           pat_bytes [PATTERN_MAX];
  int                   pat_len;
  logic [PATTERN_MAX:0] live_pos;
  logic                 ovf_flag;
  lpm_out_t             verdicts_due [$];

  int  n_items   = 0;
  int  n_results = 0;
  int  n_hits    = 0;
  int  n_ovf     = 0;
  int  n_fail    = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_left  = 0;
  int  stall_left = 0;

  // positions reachable through a wildcard are active too
  function automatic logic [PATTERN_MAX:0] closed_set(input logic [PATTERN_MAX:0] s);
    logic [PATTERN_MAX:0] r;
    r = s;
    for (int p = 0; p < pat_len; p++) begin
      if (r[p] && pat_bytes[p] == WILDCARD) r[p+1] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [PATTERN_MAX:0] fresh_set();
    logic [PATTERN_MAX:0] s;
    s = '0;
    s[0] = 1'b1;
    return closed_set(s);
  endfunction

  function automatic logic [PATTERN_MAX:0] step_set(input logic [PATTERN_MAX:0] s,
                                                   input logic [7:0] c);
    logic [PATTERN_MAX:0] nxt;
    nxt = '0;
    for (int p = 0; p < pat_len; p++) begin
      if (s[p]) begin
        if (pat_bytes[p] == WILDCARD) nxt[p] = 1'b1;
        else if (pat_bytes[p] == c) nxt[p+1] = 1'b1;
      end
    end
    return closed_set(nxt);
  endfunction

  function automatic void apply_item(input lpm_in_t it);
    lpm_out_t v;
    logic     collapse;
    collapse = 1'b0;
    case (it.operation)
      OP_CLEAR: begin
        pat_len  = 0;
        ovf_flag = 1'b0;
        live_pos = fresh_set();
      end
      OP_APPEND: begin
        collapse = it.data_byte == WILDCARD && pat_len > 0 &&
                   pat_bytes[pat_len-1] == WILDCARD;
        if (!collapse) begin
          if (pat_len >= PATTERN_MAX) begin
            ovf_flag = 1'b1;
          end else begin
            pat_bytes[pat_len] = it.data_byte;
            pat_len++;
          end
        end
        live_pos = fresh_set();
      end
      OP_SUBJECT: live_pos = step_set(live_pos, it.data_byte);
      default: begin
        v.matched          = live_pos[pat_len] && !it.null_operand && !ovf_flag;
        v.null_result      = it.null_operand;
        v.pattern_overflow = ovf_flag;
        verdicts_due.push_back(v);
        live_pos = fresh_set();
      end
    endcase
  endfunction

  task automatic send_item(input lpm_in_t it);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    apply_item(it);
    n_items++;
  endtask

  task automatic put(input lpm_op_t op, input logic [7:0] b, input logic nul);
    lpm_in_t it;
    it.operation    = op;
    it.data_byte    = b;
    it.null_operand = nul;
    send_item(it);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold when asked, otherwise random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    lpm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result %b", out_data);
        n_fail++;
      end else begin
        want = verdicts_due.pop_front();
        n_results++;
        if (want.matched) n_hits++;
        if (want.pattern_overflow) n_ovf++;
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %b, got %b", want.matched, out_data.matched);
          n_fail++;
        end
        if (out_data.null_result !== want.null_result) begin
          $error("null_result: expected %b, got %b", want.null_result,
                 out_data.null_result);
          n_fail++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %b, got %b", want.pattern_overflow,
                 out_data.pattern_overflow);
          n_fail++;
        end
      end
    end
  end

  function automatic logic [7:0] pick_byte(input bit wide);
    if (wide || $urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0:       return "a";
      1:       return "b";
      2:       return "c";
      3:       return WILDCARD;
      default: return "a";
    endcase
  endfunction

  task automatic test_directed();
    put(OP_CLEAR, 8'hFF, 1'b1);
    put(OP_EVAL, 8'hA5, 1'b0);          // empty pattern, empty subject
    put(OP_SUBJECT, 8'h00, 1'b0);
    put(OP_EVAL, 8'h00, 1'b0);          // empty pattern, one byte
    put(OP_EVAL, 8'h00, 1'b1);          // null operand
    put(OP_APPEND, "a", 1'b0);
    put(OP_APPEND, WILDCARD, 1'b0);
    put(OP_APPEND, WILDCARD, 1'b1);     // dropped
    put(OP_APPEND, 8'hFF, 1'b0);
    put(OP_SUBJECT, "a", 1'b0);
    put(OP_SUBJECT, 8'h00, 1'b0);
    put(OP_SUBJECT, 8'hFF, 1'b0);
    put(OP_EVAL, 8'hFF, 1'b0);
    put(OP_SUBJECT, "a", 1'b0);
    put(OP_SUBJECT, 8'hFF, 1'b0);
    put(OP_SUBJECT, 8'h00, 1'b0);
    put(OP_EVAL, 8'h00, 1'b0);          // trailing byte left over
    put(OP_APPEND, WILDCARD, 1'b0);
    put(OP_SUBJECT, "a", 1'b0);
    put(OP_APPEND, "b", 1'b0);          // abandons subject in flight
    put(OP_SUBJECT, "a", 1'b0);
    put(OP_SUBJECT, 8'hFF, 1'b0);
    put(OP_SUBJECT, "b", 1'b0);
    put(OP_EVAL, 8'h00, 1'b0);
    put(OP_EVAL, 8'h00, 1'b1);
    wait_drain();
  endtask

  task automatic test_overflow();
    put(OP_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < PATTERN_MAX; i++) put(OP_APPEND, 8'h40 + 8'(i), 1'b0);
    for (int i = 0; i < PATTERN_MAX; i++) put(OP_SUBJECT, 8'h40 + 8'(i), 1'b0);
    put(OP_EVAL, 8'h00, 1'b0);          // full store, exact subject
    put(OP_APPEND, 8'h00, 1'b0);        // one byte too many
    put(OP_SUBJECT, 8'h40, 1'b0);
    put(OP_EVAL, 8'h00, 1'b0);
    put(OP_APPEND, WILDCARD, 1'b0);
    put(OP_EVAL, 8'h00, 1'b1);
    put(OP_CLEAR, 8'h00, 1'b0);         // clears the sticky flag
    put(OP_EVAL, 8'h00, 1'b0);
    wait_drain();
  endtask

  // receiver holds off while evaluates pile up behind the result register
  task automatic test_backpressure();
    put(OP_CLEAR, 8'h00, 1'b0);
    put(OP_APPEND, "a", 1'b0);
    put(OP_APPEND, WILDCARD, 1'b0);
    hold_left = 80;
    repeat (12) begin
      put(OP_SUBJECT, "a", 1'b0);
      put(OP_EVAL, 8'h00, 1'b0);
    end
    wait_drain();
  endtask

  task automatic run_sequence();
    logic [7:0] pat [$];
    logic [7:0] subj [$];
    int         plen;
    int         kind;
    int         idx;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12))
        put(lpm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)));
    end else begin
      plen = (kind == 1) ? $urandom_range(56, 72) : $urandom_range(0, 8);
      pat = {};
      repeat (plen) pat.push_back(pick_byte(kind == 1));
      put(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      foreach (pat[i]) put(OP_APPEND, pat[i], 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
        subj = {};
        foreach (pat[i]) begin
          if (pat[i] == WILDCARD) repeat ($urandom_range(0, 3)) subj.push_back(pick_byte(0));
          else subj.push_back(pat[i]);
        end
        case ($urandom_range(0, 5))
          0: if (subj.size() > 0) subj[$urandom_range(0, subj.size() - 1)] = pick_byte(0);
          1: subj.push_back(pick_byte(0));
          2: begin
            if (subj.size() > 0) begin
              idx = $urandom_range(0, subj.size() - 1);
              subj.delete(idx);
            end
          end
          default: ;
        endcase
        foreach (subj[i]) put(OP_SUBJECT, subj[i], 1'($urandom_range(0, 1)));
        put(OP_EVAL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
      end
    end
  endtask

  task automatic test_random(input int upto);
    while (n_items < upto) begin
      run_sequence();
      if ($urandom_range(0, 49) == 0) wait_drain();
    end
  endtask

  task automatic test_steady(input int upto);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(upto);
  endtask

  initial begin
    pat_len  = 0;
    ovf_flag = 1'b0;
    live_pos = fresh_set();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(1420);
    test_steady(1770);
    wait_drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d items and %0d results: %0d matches, %0d overflow reports",
             n_items, n_results, n_hits, n_ovf);
    if (n_fail == 0 && verdicts_due.size() == 0) begin
      $display("tb_like_pattern_matcher_top OK");
    end else begin
      $display("tb_like_pattern_matcher_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", verdicts_due.size());
    $display("tb_like_pattern_matcher_top NOT OK");
    $finish;
  end

endmodule
